/* rtl/i2cp_pkg.sv */
// Package for the I2C address probe master.
// Holds phase codes, configuration indexes, reset values and the shared structs.
// No dependencies.
package i2cp_pkg;

    localparam int COUNT_WIDTH_DEF = 16;

    localparam int PHASE_W = 4;

    localparam logic [PHASE_W-1:0] PH_IDLE          = 4'd0;
    localparam logic [PHASE_W-1:0] PH_START_SETUP   = 4'd1;
    localparam logic [PHASE_W-1:0] PH_START_STRETCH = 4'd2;
    localparam logic [PHASE_W-1:0] PH_START_HOLD    = 4'd3;
    localparam logic [PHASE_W-1:0] PH_START_LOW     = 4'd4;
    localparam logic [PHASE_W-1:0] PH_BIT_SETUP     = 4'd5;
    localparam logic [PHASE_W-1:0] PH_BIT_HIGH      = 4'd6;
    localparam logic [PHASE_W-1:0] PH_BIT_STRETCH   = 4'd7;
    localparam logic [PHASE_W-1:0] PH_BIT_HOLD      = 4'd8;
    localparam logic [PHASE_W-1:0] PH_ACK_SETUP     = 4'd9;
    localparam logic [PHASE_W-1:0] PH_ACK_STRETCH   = 4'd10;
    localparam logic [PHASE_W-1:0] PH_ACK_HIGH      = 4'd11;
    localparam logic [PHASE_W-1:0] PH_STOP_A        = 4'd12;
    localparam logic [PHASE_W-1:0] PH_STOP_B        = 4'd13;
    localparam logic [PHASE_W-1:0] PH_STOP_C        = 4'd14;
    localparam logic [PHASE_W-1:0] PH_STOP_D        = 4'd15;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRETCH_LIM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_HOLD     = 2'd2;

    localparam logic [15:0] HALF_PERIOD_RST = 16'd5;
    localparam logic [15:0] STRETCH_LIM_RST = 16'd500;
    localparam logic [7:0]  BIT_HOLD_RST    = 8'd5;

    localparam int ADDR_W   = 7;
    localparam int NUM_BITS = 8;

    typedef struct packed {
        logic [15:0] half_period_ticks;
        logic [15:0] stretch_limit_ticks;
        logic [7:0]  bit_hold_ticks;
    } cfg_t;

    typedef struct packed {
        logic scl_drive;
        logic sda_drive;
        logic busy_res;
        logic done_res;
        logic acked;
    } res_t;

endpackage

/* rtl/i2cp_cfg.sv */
// Configuration register file of the I2C address probe master.
// Depends on i2cp_pkg for register indexes and reset values.
module i2cp_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [i2cp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [i2cp_pkg::CFG_DATA_W-1:0]   cfg_data,
    output i2cp_pkg::cfg_t                    cfg
);
    import i2cp_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period_ticks   <= HALF_PERIOD_RST;
            cfg_reg.stretch_limit_ticks <= STRETCH_LIM_RST;
            cfg_reg.bit_hold_ticks      <= BIT_HOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HALF_PERIOD: cfg_reg.half_period_ticks   <= cfg_data;
                CFG_STRETCH_LIM: cfg_reg.stretch_limit_ticks <= cfg_data;
                CFG_BIT_HOLD:    cfg_reg.bit_hold_ticks      <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/i2cp_seq.sv */
// Tick sequencer of the I2C address probe master: phase, counters and line levels.
// Depends on i2cp_pkg for phase codes and the cfg_t and res_t structs.
module i2cp_seq #(
    parameter int COUNT_WIDTH = i2cp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  logic                           command,
    input  logic [i2cp_pkg::ADDR_W-1:0]    target_address,
    input  logic                           scl_level,
    input  logic                           sda_level,
    input  i2cp_pkg::cfg_t                 cfg,
    output i2cp_pkg::res_t                 res
);
    import i2cp_pkg::*;

    localparam int CW   = COUNT_WIDTH;
    localparam int CMPW = (CW > 16) ? CW : 16;

    logic [PHASE_W-1:0] ph_reg,      ph_next;
    logic [3:0]         bit_cnt_reg, bit_cnt_next;
    logic [7:0]         shift_reg,   shift_next;
    logic [CW-1:0]      wait_reg,    wait_next;
    logic [CW-1:0]      str_reg,     str_next;
    logic               ack_reg,     ack_next;
    logic               scl_reg,     scl_next;
    logic               sda_reg,     sda_next;

    logic          expired;
    logic [CW-1:0] wait_dec;
    logic [CW-1:0] half_ld;
    logic [CW-1:0] hold_ld;
    logic [CW-1:0] chk_base;
    logic [CW-1:0] chk_inc;
    logic          chk_hit;
    logic [3:0]    bit_cnt_inc;
    logic [7:0]    shift_nb;
    logic          done;

    assign expired     = (wait_reg <= CW'(1));
    assign wait_dec    = wait_reg - CW'(1);
    assign half_ld     = CW'(cfg.half_period_ticks);
    assign hold_ld     = CW'(cfg.bit_hold_ticks);
    assign bit_cnt_inc = bit_cnt_reg + 4'd1;
    assign shift_nb    = {shift_reg[6:0], 1'b0};

    // Stretch check: the first bit-phase check starts from a cleared counter.
    assign chk_base = (ph_reg == PH_BIT_HIGH) ? '0 : str_reg;
    assign chk_inc  = (&chk_base) ? chk_base : chk_base + CW'(1);
    assign chk_hit  = (CMPW'(chk_inc) >= CMPW'(cfg.stretch_limit_ticks));

    always_comb
    begin
        ph_next      = ph_reg;
        bit_cnt_next = bit_cnt_reg;
        shift_next   = shift_reg;
        wait_next    = wait_reg;
        str_next     = str_reg;
        ack_next     = ack_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        done         = 1'b0;

        unique case (ph_reg)
            PH_IDLE:
            begin
                if (command)
                begin
                    shift_next   = {1'b0, target_address};
                    bit_cnt_next = '0;
                    ack_next     = 1'b0;
                    str_next     = '0;
                    scl_next     = 1'b1;
                    sda_next     = 1'b1;
                    wait_next    = half_ld;
                    ph_next      = PH_START_SETUP;
                end
            end
            PH_START_SETUP, PH_ACK_SETUP:
            begin
                if (expired)
                begin
                    scl_next = 1'b1;
                    str_next = '0;
                    ph_next  = (ph_reg == PH_START_SETUP) ? PH_START_STRETCH
                                                          : PH_ACK_STRETCH;
                end
                else
                begin
                    wait_next = wait_dec;
                end
            end
            PH_START_STRETCH, PH_ACK_STRETCH:
            begin
                if (scl_level)
                begin
                    if (ph_reg == PH_START_STRETCH)
                    begin
                        sda_next = 1'b0;
                        ph_next  = PH_START_HOLD;
                    end
                    else
                    begin
                        ack_next = ~sda_level;
                        ph_next  = PH_ACK_HIGH;
                    end
                    wait_next = half_ld;
                end
                else
                begin
                    str_next = chk_inc;
                    if (chk_hit)
                    begin
                        wait_next = half_ld;
                        ph_next   = PH_STOP_A;
                    end
                end
            end
            PH_START_HOLD:
            begin
                if (expired)
                begin
                    scl_next  = 1'b0;
                    wait_next = half_ld;
                    ph_next   = PH_START_LOW;
                end
                else
                begin
                    wait_next = wait_dec;
                end
            end
            PH_START_LOW:
            begin
                if (expired)
                begin
                    shift_next = shift_nb;
                    sda_next   = shift_nb[7];
                    wait_next  = half_ld;
                    ph_next    = PH_BIT_SETUP;
                end
                else
                begin
                    wait_next = wait_dec;
                end
            end
            PH_BIT_SETUP:
            begin
                if (expired)
                begin
                    scl_next  = 1'b1;
                    wait_next = half_ld;
                    ph_next   = PH_BIT_HIGH;
                end
                else
                begin
                    wait_next = wait_dec;
                end
            end
            PH_BIT_HIGH, PH_BIT_STRETCH:
            begin
                if ((ph_reg == PH_BIT_HIGH) && !expired)
                begin
                    wait_next = wait_dec;
                end
                else
                begin
                    // The bit check runs in the tick the high half period ends.
                    str_next = chk_base;
                    ph_next  = PH_BIT_STRETCH;
                    if (scl_level)
                    begin
                        scl_next  = 1'b0;
                        wait_next = hold_ld;
                        ph_next   = PH_BIT_HOLD;
                    end
                    else
                    begin
                        str_next = chk_inc;
                        if (chk_hit)
                        begin
                            wait_next = half_ld;
                            ph_next   = PH_STOP_A;
                        end
                    end
                end
            end
            PH_BIT_HOLD:
            begin
                if (expired)
                begin
                    bit_cnt_next = bit_cnt_inc;
                    wait_next    = half_ld;
                    if (bit_cnt_inc < 4'(NUM_BITS))
                    begin
                        shift_next = shift_nb;
                        sda_next   = shift_nb[7];
                        ph_next    = PH_BIT_SETUP;
                    end
                    else
                    begin
                        sda_next = 1'b1;
                        ph_next  = PH_ACK_SETUP;
                    end
                end
                else
                begin
                    wait_next = wait_dec;
                end
            end
            PH_ACK_HIGH:
            begin
                if (expired)
                begin
                    scl_next  = 1'b0;
                    wait_next = half_ld;
                    ph_next   = PH_STOP_A;
                end
                else
                begin
                    wait_next = wait_dec;
                end
            end
            PH_STOP_A, PH_STOP_B, PH_STOP_C:
            begin
                if (expired)
                begin
                    wait_next = half_ld;
                    if (ph_reg == PH_STOP_A)
                    begin
                        sda_next = 1'b0;
                        ph_next  = PH_STOP_B;
                    end
                    else if (ph_reg == PH_STOP_B)
                    begin
                        scl_next = 1'b1;
                        ph_next  = PH_STOP_C;
                    end
                    else
                    begin
                        sda_next = 1'b1;
                        ph_next  = PH_STOP_D;
                    end
                end
                else
                begin
                    wait_next = wait_dec;
                end
            end
            PH_STOP_D:
            begin
                if (expired)
                begin
                    ph_next   = PH_IDLE;
                    wait_next = '0;
                    done      = 1'b1;
                end
                else
                begin
                    wait_next = wait_dec;
                end
            end
            default:
            begin
                ph_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg      <= PH_IDLE;
            bit_cnt_reg <= '0;
            shift_reg   <= '0;
            wait_reg    <= '0;
            str_reg     <= '0;
            ack_reg     <= 1'b0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
        end
        else if (adv)
        begin
            ph_reg      <= ph_next;
            bit_cnt_reg <= bit_cnt_next;
            shift_reg   <= shift_next;
            wait_reg    <= wait_next;
            str_reg     <= str_next;
            ack_reg     <= ack_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
        end
    end

    always_comb
    begin
        res.scl_drive = scl_next;
        res.sda_drive = sda_next;
        res.busy_res  = (ph_next != PH_IDLE);
        res.done_res  = done;
        res.acked     = done & ack_next;
    end

endmodule

/* rtl/i2cp_out_reg.sv */
// Result register of the I2C address probe master with valid/ready handshake.
// Depends on i2cp_pkg for the res_t struct.
module i2cp_out_reg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  i2cp_pkg::res_t res_in,
    output logic           can_load,
    output i2cp_pkg::res_t res_out,
    output logic           res_valid,
    input  logic           res_ready
);
    import i2cp_pkg::*;

    logic valid_reg, valid_next;
    res_t data_reg;

    // The register takes a new item when empty or when its item leaves now.
    assign can_load   = !valid_reg || res_ready;
    assign valid_next = load || (valid_reg && !res_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res_in;
        end
    end

    assign res_out   = data_reg;
    assign res_valid = valid_reg;

endmodule

/* rtl/i2c_address_probe_master.sv */
// Latency: the result of an item is valid in the cycle after the item is accepted.
// Throughput: one item per cycle while the result register is free or drains; each tick is a single
// update of the phase sequencer and its counters, registered straight into the result register.
// Reset: asynchronous, active low; the sequencer goes idle with both lines released,
// the configuration registers take their defaults and no result is pending.
// Top level of the I2C address probe master; depends on i2cp_pkg, i2cp_cfg,
// i2cp_seq and i2cp_out_reg.
module i2c_address_probe_master #(
    parameter int COUNT_WIDTH = i2cp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [i2cp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [i2cp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  logic                              command,
    input  logic [i2cp_pkg::ADDR_W-1:0]       target_address,
    input  logic                              scl_level,
    input  logic                              sda_level,
    output logic                              res_valid,
    input  logic                              res_ready,
    output logic                              scl_drive,
    output logic                              sda_drive,
    output logic                              busy_res,
    output logic                              done_res,
    output logic                              acked
);
    import i2cp_pkg::*;

    cfg_t cfg;
    res_t res_comb;
    res_t res_q;
    logic can_load;
    logic accept;

    // An item is taken whenever the result register is free or drains this cycle,
    // so a pending result never stalls the tick stream by more than the consumer does.
    assign cmd_ready = can_load;
    assign accept    = cmd_valid && cmd_ready;

    // Configuration registers; the user must write them only while no item is in flight,
    // the block itself does not enforce it. A write during a probe applies from the next wait load on.
    i2cp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The sequencer advances its state exactly once per accepted item and
    // presents the post-tick line levels and status combinationally.
    i2cp_seq #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (accept),
        .command        (command),
        .target_address (target_address),
        .scl_level      (scl_level),
        .sda_level      (sda_level),
        .cfg            (cfg),
        .res            (res_comb)
    );

    // One result item per input item, held until the consumer takes it.
    i2cp_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .res_in    (res_comb),
        .can_load  (can_load),
        .res_out   (res_q),
        .res_valid (res_valid),
        .res_ready (res_ready)
    );

    assign scl_drive = res_q.scl_drive;
    assign sda_drive = res_q.sda_drive;
    assign busy_res  = res_q.busy_res;
    assign done_res  = res_q.done_res;
    assign acked     = res_q.acked;

    // A finished probe always reports the block idle.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && done_res |-> !busy_res)
        else $error("done reported while still busy");

    // An ACK result only comes with the completion pulse.
    a_ack_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && acked |-> done_res)
        else $error("acked without done");

    // When idle, both bus lines are released.
    a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !busy_res |-> scl_drive && sda_drive)
        else $error("bus line driven while idle");

    // A stalled result blocks new items so none is overwritten.
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |-> !cmd_ready)
        else $error("input accepted while result stalled");

endmodule

/* verif/tb_i2c_address_probe_master.sv */
// Self-checking testbench for the I2C address probe master.
// A line tracker class predicts the drive lines, busy, done and ack for every tick item;
// depends on i2cp_pkg and the i2c_address_probe_master RTL.
module tb_i2c_address_probe_master;

    timeunit 1ns;
    timeprecision 1ps;

    import i2cp_pkg::*;

    localparam int          CLK_PERIOD      = 12;
    localparam int unsigned RANDOM_ITEMS    = 400;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    // Longest legal run of cycles without any handshake is the receiver hold-off plus a
    // drain and a few register writes, so this leaves a wide margin.
    localparam int unsigned QUIET_LIMIT     = 10000;

    // Phase groups in which the slave may stretch SCL. The bit group covers the tick where
    // the high half period expires as well as the stretch wait that follows it.
    localparam logic [15:0] MASK_START = 16'd1 << PH_START_STRETCH;
    localparam logic [15:0] MASK_BIT   = (16'd1 << PH_BIT_HIGH) | (16'd1 << PH_BIT_STRETCH);
    localparam logic [15:0] MASK_ACK   = 16'd1 << PH_ACK_STRETCH;

    typedef enum logic [1:0] {POLL_WAIT, POLL_HIGH, POLL_TIMEOUT} poll_t;

    // Tracks the probe sequencer tick by tick and holds the line states that the block
    // should report, oldest first.
    class line_tracker;
        logic [15:0]        half_period;
        logic [15:0]        stretch_lim;
        logic [7:0]         bit_hold;
        logic [PHASE_W-1:0] phase;
        logic [3:0]         bit_cnt;
        logic [7:0]         addr_sh;
        logic [15:0]        wait_cnt;
        logic [15:0]        stretch_cnt;
        logic               ack_seen;
        logic               scl_o;
        logic               sda_o;
        res_t               line_states[$];
        int unsigned        errors;

        function new();
            half_period = HALF_PERIOD_RST;
            stretch_lim = STRETCH_LIM_RST;
            bit_hold    = BIT_HOLD_RST;
            phase       = PH_IDLE;
            bit_cnt     = '0;
            addr_sh     = '0;
            wait_cnt    = '0;
            stretch_cnt = '0;
            ack_seen    = 1'b0;
            scl_o       = 1'b1;
            sda_o       = 1'b1;
            errors      = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_HALF_PERIOD: half_period = val;
                CFG_STRETCH_LIM: stretch_lim = val;
                CFG_BIT_HOLD:    bit_hold = val[7:0];
                default:         ;
            endcase
        endfunction

        function bit busy();
            return phase != PH_IDLE;
        endfunction

        function int unsigned pending();
            return line_states.size();
        endfunction

        // True when the next tick item has its scl_level looked at.
        function bit scl_sampled();
            return phase == PH_START_STRETCH || phase == PH_BIT_STRETCH
                || phase == PH_ACK_STRETCH || (phase == PH_BIT_HIGH && wait_cnt <= 16'd1);
        endfunction

        function void load_wait(logic [15:0] n, logic [PHASE_W-1:0] nxt);
            wait_cnt = n;
            phase    = nxt;
        endfunction

        function bit wait_done();
            if (wait_cnt <= 16'd1)
                return 1'b1;
            wait_cnt = wait_cnt - 16'd1;
            return 1'b0;
        endfunction

        function poll_t poll_scl(logic scl);
            if (scl)
                return POLL_HIGH;
            if (stretch_cnt != 16'hFFFF)
                stretch_cnt = stretch_cnt + 16'd1;
            if (stretch_cnt >= stretch_lim)
                return POLL_TIMEOUT;
            return POLL_WAIT;
        endfunction

        function void shift_bit();
            addr_sh = addr_sh << 1;
            sda_o   = addr_sh[7];
            load_wait(half_period, PH_BIT_SETUP);
        endfunction

        function void bit_poll(logic scl);
            poll_t pr;
            pr = poll_scl(scl);
            if (pr == POLL_HIGH)
            begin
                scl_o = 1'b0;
                load_wait({8'd0, bit_hold}, PH_BIT_HOLD);
            end
            else if (pr == POLL_TIMEOUT)
                load_wait(half_period, PH_STOP_A);
        endfunction

        // Advances the sequencer by one accepted tick item and queues the lines it leaves.
        function void take_tick(logic cmd, logic [ADDR_W-1:0] addr, logic scl, logic sda);
            res_t  lines;
            logic  done;
            poll_t pr;
            done = 1'b0;
            case (phase)
                PH_IDLE:
                    if (cmd)
                    begin
                        addr_sh     = {1'b0, addr};
                        bit_cnt     = '0;
                        ack_seen    = 1'b0;
                        stretch_cnt = '0;
                        scl_o       = 1'b1;
                        sda_o       = 1'b1;
                        load_wait(half_period, PH_START_SETUP);
                    end
                PH_START_SETUP:
                    if (wait_done())
                    begin
                        scl_o       = 1'b1;
                        stretch_cnt = '0;
                        phase       = PH_START_STRETCH;
                    end
                PH_START_STRETCH:
                begin
                    pr = poll_scl(scl);
                    if (pr == POLL_HIGH)
                    begin
                        sda_o = 1'b0;
                        load_wait(half_period, PH_START_HOLD);
                    end
                    else if (pr == POLL_TIMEOUT)
                        load_wait(half_period, PH_STOP_A);
                end
                PH_START_HOLD:
                    if (wait_done())
                    begin
                        scl_o = 1'b0;
                        load_wait(half_period, PH_START_LOW);
                    end
                PH_START_LOW:
                    if (wait_done())
                        shift_bit();
                PH_BIT_SETUP:
                    if (wait_done())
                    begin
                        scl_o = 1'b1;
                        load_wait(half_period, PH_BIT_HIGH);
                    end
                PH_BIT_HIGH:
                    if (wait_done())
                    begin
                        stretch_cnt = '0;
                        phase       = PH_BIT_STRETCH;
                        bit_poll(scl);
                    end
                PH_BIT_STRETCH:
                    bit_poll(scl);
                PH_BIT_HOLD:
                    if (wait_done())
                    begin
                        bit_cnt = bit_cnt + 4'd1;
                        if (bit_cnt < NUM_BITS)
                            shift_bit();
                        else
                        begin
                            sda_o = 1'b1;
                            load_wait(half_period, PH_ACK_SETUP);
                        end
                    end
                PH_ACK_SETUP:
                    if (wait_done())
                    begin
                        scl_o       = 1'b1;
                        stretch_cnt = '0;
                        phase       = PH_ACK_STRETCH;
                    end
                PH_ACK_STRETCH:
                begin
                    pr = poll_scl(scl);
                    if (pr == POLL_HIGH)
                    begin
                        ack_seen = !sda;
                        load_wait(half_period, PH_ACK_HIGH);
                    end
                    else if (pr == POLL_TIMEOUT)
                        load_wait(half_period, PH_STOP_A);
                end
                PH_ACK_HIGH:
                    if (wait_done())
                    begin
                        scl_o = 1'b0;
                        load_wait(half_period, PH_STOP_A);
                    end
                PH_STOP_A:
                    if (wait_done())
                    begin
                        sda_o = 1'b0;
                        load_wait(half_period, PH_STOP_B);
                    end
                PH_STOP_B:
                    if (wait_done())
                    begin
                        scl_o = 1'b1;
                        load_wait(half_period, PH_STOP_C);
                    end
                PH_STOP_C:
                    if (wait_done())
                    begin
                        sda_o = 1'b1;
                        load_wait(half_period, PH_STOP_D);
                    end
                PH_STOP_D:
                    if (wait_done())
                    begin
                        phase    = PH_IDLE;
                        wait_cnt = '0;
                        done     = 1'b1;
                    end
                default:
                    phase = PH_IDLE;
            endcase
            lines.scl_drive = scl_o;
            lines.sda_drive = sda_o;
            lines.busy_res  = phase != PH_IDLE;
            lines.done_res  = done;
            lines.acked     = done & ack_seen;
            line_states.push_back(lines);
        endfunction

        function void cmp_field(string field, logic want, logic got);
            if (got !== want)
            begin
                $error("%s: expected %0b, got %0b", field, want, got);
                errors++;
            end
        endfunction

        function void match_lines(res_t got);
            res_t want;
            if (line_states.size() == 0)
            begin
                $error("result item arrived with no tick item outstanding");
                errors++;
                return;
            end
            want = line_states.pop_front();
            cmp_field("scl_drive", want.scl_drive, got.scl_drive);
            cmp_field("sda_drive", want.sda_drive, got.sda_drive);
            cmp_field("busy_res", want.busy_res, got.busy_res);
            cmp_field("done_res", want.done_res, got.done_res);
            cmp_field("acked", want.acked, got.acked);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  cmd_valid;
    logic                  cmd_ready;
    logic                  command;
    logic [ADDR_W-1:0]     target_address;
    logic                  scl_level;
    logic                  sda_level;
    logic                  res_valid;
    logic                  res_ready;
    logic                  scl_drive;
    logic                  sda_drive;
    logic                  busy_res;
    logic                  done_res;
    logic                  acked;

    line_tracker probe = new();

    // Set by the stimulus to ask the result side for one long hold-off; cleared there.
    bit          hold_req = 1'b0;
    // While set, neither side inserts idle cycles.
    bit          steady = 1'b0;
    int unsigned n_items = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    i2c_address_probe_master dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .command        (command),
        .target_address (target_address),
        .scl_level      (scl_level),
        .sda_level      (sda_level),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .scl_drive      (scl_drive),
        .sda_drive      (sda_drive),
        .busy_res       (busy_res),
        .done_res       (done_res),
        .acked          (acked)
    );

    // Offers one tick item and returns at the edge where it is accepted. Outputs are read
    // right after the edge, before any flop of the block has taken its new value, so the
    // handshake seen here is the one the block saw. The valid is only lowered when a gap
    // is chosen, so it is never lowered and raised within one time step.
    task automatic push_tick(input logic c, input logic [ADDR_W-1:0] a, input logic s,
                             input logic d);
        if (!steady && $urandom_range(99) < 8)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        cmd_valid      <= 1'b1;
        command        <= c;
        target_address <= a;
        scl_level      <= s;
        sda_level      <= d;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        probe.take_tick(c, a, s, d);
        n_items++;
    endtask

    // Stops offering items and waits until every result item has come back, then lets
    // the registered result path of the block settle before returning.
    task automatic drain();
        cmd_valid <= 1'b0;
        while (probe.pending() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Writes one register at the next edge; the caller lowers cfg_we after its last write
    // so that back-to-back writes never touch cfg_we twice in one time step.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        probe.set_reg(idx, val);
    endtask

    task automatic set_config(input logic [15:0] hp, input logic [15:0] lim,
                              input logic [7:0] hold);
        drain();
        cfg_write(CFG_HALF_PERIOD, hp);
        cfg_write(CFG_STRETCH_LIM, lim);
        cfg_write(CFG_BIT_HOLD, {8'd0, hold});
        cfg_we <= 1'b0;
    endtask

    // Runs one probe from its start command until the sequencer is idle again. The slave
    // side follows the master on SDA, answers the ACK slot with acks, and stretches SCL
    // in the phase groups of stall_mask: on each visit, with stall_pct percent chance, it
    // holds SCL low for stall_lo..stall_hi sampled ticks. Noise adds ignored start
    // commands and flipped line levels. A nonzero retime_hp rewrites the half period in
    // the middle of the probe, after the block has drained.
    task automatic run_probe(input logic [ADDR_W-1:0] addr, input bit acks,
                             input logic [15:0] stall_mask, input int unsigned stall_pct,
                             input int unsigned stall_lo, input int unsigned stall_hi,
                             input int unsigned noise_pct, input logic [15:0] retime_hp);
        int unsigned low_left;
        int unsigned ticks;
        bit          in_visit;
        logic        scl;
        logic        sda;
        logic        cmd;
        low_left = 0;
        ticks    = 0;
        in_visit = 1'b0;
        push_tick(1'b1, addr, 1'b1, 1'b1);
        while (probe.busy())
        begin
            if (retime_hp != 16'd0 && ticks == 20)
            begin
                drain();
                cfg_write(CFG_HALF_PERIOD, retime_hp);
                cfg_we <= 1'b0;
            end
            scl = 1'b1;
            if (probe.scl_sampled() && stall_mask[probe.phase])
            begin
                if (!in_visit)
                begin
                    in_visit = 1'b1;
                    low_left = ($urandom_range(99) < stall_pct)
                             ? $urandom_range(stall_lo, stall_hi) : 0;
                end
                if (low_left != 0)
                begin
                    scl = 1'b0;
                    low_left--;
                end
            end
            else
                in_visit = 1'b0;
            sda = (probe.phase == PH_ACK_STRETCH) ? !acks : probe.sda_o;
            cmd = 1'b0;
            if ($urandom_range(99) < noise_pct)
            begin
                case ($urandom_range(2))
                    0:       cmd = 1'b1;
                    1:       scl = !scl;
                    default: sda = !sda;
                endcase
            end
            push_tick(cmd, 7'($urandom_range(127)), scl, sda);
            ticks++;
        end
    endtask

    // Result side: checks each accepted result item, idles now and then, and serves the
    // one long hold-off during which the block fills up and stalls its input.
    initial
    begin : result_sink
        int unsigned hold_left;
        hold_left = 0;
        res_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_valid && res_ready)
                probe.match_lines({scl_drive, sda_drive, busy_res, done_res, acked});
            if (hold_left != 0)
            begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
                res_ready <= 1'b0;
            end
            else
                res_ready <= steady || ($urandom_range(99) >= 8);
        end
    end

    // Ends the run when no item moves on either channel for too long.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_i2c_address_probe_master: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned first_random;
        int unsigned round;
        int unsigned hi;
        int unsigned pick;
        logic [15:0] hp;
        logic [15:0] lim;
        logic [7:0]  hold;
        logic [15:0] mask;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_HALF_PERIOD;
        cfg_data       = '0;
        cmd_valid      = 1'b0;
        command        = 1'b0;
        target_address = '0;
        scl_level      = 1'b1;
        sda_level      = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults: a probe of the all-ones address with an acking slave, with
        // start commands arriving while busy that the block must treat as plain ticks.
        run_probe(7'h7F, 1'b1, '0, 0, 1, 1, 10, '0);

        // Shortest timing with zero hold: every wait acts as a single tick.
        set_config(16'd1, 16'd1, 8'd0);
        run_probe(7'h00, 1'b0, '0, 0, 1, 1, 0, '0);
        // Stretch limit of one fails at the first low sample after the START release.
        run_probe(7'h55, 1'b1, MASK_START, 100, 1, 1, 0, '0);

        // Stretching inside the address bits and the ACK slot, just under and at the limit.
        set_config(16'd1, 16'd3, 8'd0);
        run_probe(7'h2A, 1'b1, MASK_BIT, 100, 2, 2, 0, '0);
        run_probe(7'h15, 1'b1, MASK_BIT, 100, 3, 3, 0, '0);
        run_probe(7'h6B, 1'b1, MASK_ACK, 100, 3, 3, 0, '0);
        run_probe(7'h33, 1'b0, MASK_ACK, 100, 2, 2, 0, '0);

        // Longest stretch limit with a long hold, with the half period changed in
        // mid-probe so that it applies from the next wait load on.
        set_config(16'd2, 16'd65535, 8'd12);
        run_probe(7'h4C, 1'b1, MASK_START | MASK_BIT | MASK_ACK, 50, 1, 40, 0, 16'd3);

        // A longer stretch limit running out in the ACK slot.
        set_config(16'd1, 16'd30, 8'd0);
        run_probe(7'h01, 1'b1, MASK_ACK, 100, 35, 35, 0, '0);

        // A long half period, cut short by a failed START so the run stays bounded.
        set_config(16'd40, 16'd1, 8'd1);
        run_probe(7'h40, 1'b0, MASK_START, 100, 1, 1, 0, '0);

        // Random probes: mostly small timing, random stretching in random phase groups,
        // a little noise, and short idle stretches between probes.
        first_random = n_items;
        round        = 0;
        hp           = 16'd1;
        lim          = 16'd1;
        while (n_items - first_random < RANDOM_ITEMS)
        begin
            if (round % 4 == 0)
            begin
                hp   = ($urandom_range(99) < 85) ? 16'($urandom_range(1, 4))
                                                 : 16'($urandom_range(5, 12));
                lim  = ($urandom_range(99) < 85) ? 16'($urandom_range(1, 8))
                                                 : 16'($urandom_range(100, 400));
                pick = $urandom_range(99);
                hold = (pick < 80) ? 8'($urandom_range(0, 6)) : ((pick < 90) ? 8'd20 : 8'd0);
                set_config(hp, lim, hold);
            end
            steady = (round >= 1 && round < 3);
            if (round == 0)
                hold_req = 1'b1;
            pick = $urandom_range(7);
            mask = (pick[0] ? MASK_START : 16'd0) | (pick[1] ? MASK_BIT : 16'd0)
                 | (pick[2] ? MASK_ACK : 16'd0);
            hi   = (int'(lim) + 2 > 12) ? 12 : int'(lim) + 2;
            run_probe(7'($urandom_range(127)), 1'($urandom_range(1)), mask, 30, 1, hi, 5,
                      '0);
            repeat ($urandom_range(0, 4))
                push_tick(1'b0, 7'($urandom_range(127)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            round++;
        end
        steady = 1'b0;

        drain();
        repeat (4) @(posedge clk);
        if (probe.errors == 0 && probe.pending() == 0)
            $display("tb_i2c_address_probe_master: done, clean");
        else
            $display("tb_i2c_address_probe_master: done, errors");
        $finish;
    end

endmodule
